FILE: rtl/accel_magnitude_rise_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer magnitude rise detector
// Shared property forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MAGNITUDE_RISE_DETECTOR_DEFINES_SVH
`define ACCEL_MAGNITUDE_RISE_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMRD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AMRD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/amrd_pkg.sv
// ----------------------------------------------------------------------------
// amrd_pkg
// Widths, reset values, register codes and window index helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amrd_pkg;

  localparam int WIN_DEPTH  = 512;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);

  localparam int ACCEL_W    = 16;
  localparam int MAG_W      = 20;
  localparam int THR_W      = 20;
  localparam int DEC_W      = 3;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 32;
  localparam int RAD_W      = 2 * MAG_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [THR_W-1:0] RISE_THRESHOLD_RESET = THR_W'(115935);
  localparam logic [DEC_W-1:0] DECIMATION_RESET     = DEC_W'(3);
  localparam logic [MAG_W-1:0] PRESEED_RESET        = MAG_W'(131744);

  typedef logic signed [ACCEL_W-1:0] accel_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [WIN_AW-1:0]         win_addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RISE_THRESHOLD = 2'd0,
    REG_DECIMATION     = 2'd1,
    REG_PRESEED        = 2'd2
  } cfg_reg_t;

  function automatic win_addr_t win_inc(win_addr_t a);
    return (a == WIN_AW'(WIN_DEPTH - 1)) ? '0 : a + WIN_AW'(1);
  endfunction

  function automatic win_addr_t win_dec(win_addr_t a);
    return (a == '0) ? WIN_AW'(WIN_DEPTH - 1) : a - WIN_AW'(1);
  endfunction

endpackage

FILE: rtl/amrd_if.sv
// ----------------------------------------------------------------------------
// amrd_sample_if / amrd_result_if
// Valid/ready channels for accelerometer samples and detector results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface amrd_sample_if;
  import amrd_pkg::*;

  logic   valid;
  logic   ready;
  accel_t accel_x;
  accel_t accel_y;
  accel_t accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface amrd_result_if;
  import amrd_pkg::*;

  logic valid;
  logic ready;
  logic set_detected;
  logic sample_used;
  mag_t magnitude_out;

  modport source (output valid, output set_detected, output sample_used,
                  output magnitude_out, input ready);
  modport sink   (input valid, input set_detected, input sample_used,
                  input magnitude_out, output ready);
endinterface

FILE: rtl/accel_magnitude_rise_detector.sv
// ----------------------------------------------------------------------------
// accel_magnitude_rise_detector
// Decimates accelerometer samples, computes the magnitude of each kept one
// and flags a rise when a running window difference sum passes a threshold.
// ----------------------------------------------------------------------------
// Samples arrive on the samples channel and each gives exactly one transfer
// on the results channel, in order. Configuration must be written through
// cfg_we / cfg_index / cfg_data only while the block is idle; the block
// itself does not enforce this. A skipped sample goes straight to the
// result load. For a kept sample the axes are squared on one shared
// multiplier while the three window neighbors are read, then the bit-serial
// square root runs, then the sum update, the window write, an optional
// preseed write and the result load follow.
// After reset the 512-entry window store is cleared, entry 0 getting the
// reset preseed value; no sample is taken during that time, while
// configuration writes are taken as ever.
// The result sits in an output register. While the receiver stalls, the
// block holds a finished result until that register is free, and does not
// take a new sample until its result has been loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_magnitude_rise_detector (
  input  logic                            clk,
  input  logic                            rst,
  amrd_sample_if.sink                     samples,
  amrd_result_if.source                   results,
  input  logic                            cfg_we,
  input  logic [amrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amrd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import amrd_pkg::*;

  `include "accel_magnitude_rise_detector_defines.svh"

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_SQ      = 8'b0000_0100,
    ST_ROOT    = 8'b0000_1000,
    ST_SUM     = 8'b0001_0000,
    ST_CMP     = 8'b0010_0000,
    ST_PRESEED = 8'b0100_0000,
    ST_RESULT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [THR_W-1:0] rise_threshold;
  logic [DEC_W-1:0] decim_ratio;
  mag_t             preseed_magnitude;

  logic [DEC_W-1:0] phase;
  logic [DEC_W-1:0] factor;
  logic             keep;
  logic             in_xfer;
  logic             out_load;

  accel_t x;
  accel_t y;
  accel_t z;
  logic [1:0]      sq_cnt;
  accel_t          mul_a;
  logic signed [2*ACCEL_W-1:0] prod;
  logic [SQ_W-1:0] acc;

  logic            sq_start;
  logic            sq_done;
  mag_t            root;

  win_addr_t       idx;
  win_addr_t       raddr;
  win_addr_t       waddr;
  mag_t            wdata;
  logic            we;
  mag_t            rdata;
  mag_t            window_mem [WIN_DEPTH];
  win_addr_t       clr_cnt;

  mag_t            prev_val;
  mag_t            next1_val;
  mag_t            next2_val;
  logic signed [MAG_W+1:0] part;
  logic signed [MAG_W+2:0] delta;
  logic signed [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0]        sum;
  logic                    hit_now;
  logic                    hit;
  logic                    used;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_threshold    <= RISE_THRESHOLD_RESET;
      decim_ratio       <= DECIMATION_RESET;
      preseed_magnitude <= PRESEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RISE_THRESHOLD: rise_threshold    <= THR_W'(cfg_data);
        REG_DECIMATION:     decim_ratio       <= DEC_W'(cfg_data);
        REG_PRESEED:        preseed_magnitude <= MAG_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign samples.ready = (state == ST_IDLE);
  assign in_xfer       = samples.valid && samples.ready;
  assign out_load      = (state == ST_RESULT) && (!results.valid || results.ready);

  assign factor = (decim_ratio == '0) ? DEC_W'(1) : decim_ratio;
  assign keep   = (phase == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_cnt == WIN_AW'(WIN_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:    if (in_xfer) state_next = keep ? ST_SQ : ST_RESULT;
      ST_SQ:      if (sq_cnt == 2'd3) state_next = ST_ROOT;
      ST_ROOT:    if (sq_done) state_next = ST_SUM;
      ST_SUM:     state_next = ST_CMP;
      ST_CMP:     state_next = hit_now ? ST_PRESEED : ST_RESULT;
      ST_PRESEED: state_next = ST_RESULT;
      ST_RESULT:  if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      phase   <= '0;
      idx     <= WIN_AW'(1);
      sum     <= '0;
      sq_cnt  <= '0;
      hit     <= 1'b0;
      used    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + WIN_AW'(1);
      end
      if (in_xfer) begin
        phase  <= (phase >= factor - DEC_W'(1)) ? '0 : phase + DEC_W'(1);
        used   <= keep;
        hit    <= 1'b0;
        sq_cnt <= '0;
      end
      if (state == ST_SQ) begin
        sq_cnt <= sq_cnt + 2'd1;
      end
      if (state == ST_SUM) begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
          sum <= sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          sum <= sum_wide[SUM_W-1:0];
        end
      end
      if (state == ST_CMP) begin
        hit <= hit_now;
        if (hit_now) begin
          sum <= '0;
          idx <= WIN_AW'(1);
        end else begin
          idx <= win_inc(idx);
        end
      end
    end
  end

  // Axis squares on one multiplier, one axis per cycle.
  always_comb begin
    case (sq_cnt)
      2'd0:    mul_a = x;
      2'd1:    mul_a = y;
      2'd2:    mul_a = z;
      default: mul_a = '0;
    endcase
  end

  assign prod = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x   <= samples.accel_x;
      y   <= samples.accel_y;
      z   <= samples.accel_z;
      acc <= '0;
    end else if (state == ST_SQ && sq_cnt != 2'd3) begin
      acc <= acc + $unsigned(prod);
    end
  end

  assign sq_start = (state == ST_SQ) && (sq_cnt == 2'd3);

  amrd_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .sum_sq (acc),
    .done   (sq_done),
    .root   (root)
  );

  // Window neighbor reads are issued while the squares accumulate.
  always_comb begin
    case (sq_cnt)
      2'd0:    raddr = win_dec(idx);
      2'd1:    raddr = win_inc(idx);
      default: raddr = win_inc(win_inc(idx));
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = root;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = (clr_cnt == '0) ? PRESEED_RESET : '0;
      end
      ST_CMP: begin
        we = 1'b1;
      end
      ST_PRESEED: begin
        we    = 1'b1;
        waddr = '0;
        wdata = preseed_magnitude;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      window_mem[waddr] <= wdata;
    end
    rdata <= window_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_SQ) begin
      case (sq_cnt)
        2'd1:    prev_val  <= rdata;
        2'd2:    next1_val <= rdata;
        2'd3:    next2_val <= rdata;
        default: ;
      endcase
    end
    if (state == ST_ROOT) begin
      part <= $signed({2'b00, next1_val}) - $signed({2'b00, prev_val})
            - $signed({2'b00, next2_val});
    end
  end

  assign delta    = $signed({3'b000, root}) + $signed({part[MAG_W+1], part});
  assign sum_wide = $signed({sum[SUM_W-1], sum})
                  + $signed({{(SUM_W-MAG_W-2){delta[MAG_W+2]}}, delta});
  assign hit_now  = $signed({sum[SUM_W-1], sum})
                  > $signed({{(SUM_W+1-THR_W){1'b0}}, rise_threshold});

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.set_detected  <= hit;
      results.sample_used   <= used;
      results.magnitude_out <= used ? root : '0;
    end
  end

  `AMRD_ASSERT_NEXT(a_accept_starts_work, in_xfer, (state == ST_SQ || state == ST_RESULT), "accepted sample did not start work")
  `AMRD_ASSERT_NEXT(a_result_waits, (state == ST_RESULT && results.valid && !results.ready), (state == ST_RESULT), "pending result overwritten")
  `AMRD_ASSERT_NEXT(a_hit_restarts, (state == ST_CMP && hit_now), (sum == '0 && idx == WIN_AW'(1)), "detection did not clear sum and index")
  `AMRD_ASSERT_NOW(a_root_in_place, sq_done, (state == ST_ROOT), "square root finished outside its state")

endmodule

FILE: rtl/amrd_sqrt.sv
// ----------------------------------------------------------------------------
// amrd_sqrt
// Bit-serial restoring square root: the radicand shifts out two bits per
// cycle and the root gains one bit per cycle, giving a MAG_W-bit root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amrd_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [amrd_pkg::SQ_W-1:0] sum_sq,
  output logic                      done,
  output amrd_pkg::mag_t            root
);
  import amrd_pkg::*;

  localparam int STEP_W = $clog2(MAG_W);
  localparam int REM_W  = MAG_W + 1;

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic              busy;

  logic [REM_W+1:0]  trial_rem;
  logic [REM_W+1:0]  trial_sub;
  logic              fits;

  assign trial_rem = {rem, rad[RAD_W-1 -: 2]};
  assign trial_sub = {1'b0, root, 2'b01};
  assign fits      = (trial_rem >= trial_sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {sum_sq, {(RAD_W - SQ_W){1'b0}}};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? REM_W'(trial_rem - trial_sub) : REM_W'(trial_rem);
      root <= {root[MAG_W-2:0], fits};
    end
  end

endmodule
